@@ hw/rtl/frt_pkg.sv @@
// shared types and constants of the fragment reassembly tracker
// used by frt_match, frt_table and fragment_reassembly_tracker; no dependencies
`default_nettype none

package frt_pkg;

  localparam int TABLE_SLOTS_DEF   = 8;
  localparam int MAX_FRAGMENTS_DEF = 64;

  localparam int SRC_W    = 48;
  localparam int ID_W     = 16;
  localparam int BYTE_W   = 8;
  localparam int CNT_W    = 7;   // holds a fragment total up to 64
  localparam int STATUS_W = 3;
  localparam int CAR_W    = 2;
  localparam int SLOT_W   = 3;

  // input beat: src_mac, msg_id, frag_index, frag_total, frame_len
  localparam int IN_DATA_W  = SRC_W + ID_W + 3 * BYTE_W;
  // result beat: status, car_number, slot_used, done_id
  localparam int OUT_DATA_W = STATUS_W + CAR_W + SLOT_W + ID_W;

  // frame length includes a 4-byte header plus at least one payload byte
  localparam logic [BYTE_W-1:0] MIN_FRAME_LEN = 8'd5;

  localparam logic [STATUS_W-1:0] ST_STORED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_COMPLETE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  localparam logic [CAR_W-1:0] CAR_NONE    = 2'd0;
  localparam logic [CAR_W-1:0] CAR_LOWEST  = 2'd1;
  localparam logic [CAR_W-1:0] CAR_HIGHEST = 2'd2;

  // lookup key of one partial message
  typedef struct packed {
    logic [SRC_W-1:0] src;
    logic [ID_W-1:0]  id;
  } frt_key_t;

endpackage

`default_nettype wire

@@ hw/rtl/frt_match.sv @@
// key compare unit, shared by every step of the slot scan
// depends on frt_pkg
`default_nettype none

module frt_match (
  input  frt_pkg::frt_key_t slot_key,
  input  frt_pkg::frt_key_t probe_key,
  input  logic              slot_valid,
  output logic              hit,
  output logic              free
);
  import frt_pkg::*;

  assign hit  = slot_valid && (slot_key == probe_key);
  assign free = !slot_valid;

endmodule

`default_nettype wire

@@ hw/rtl/frt_table.sv @@
// slot table: valid bits in flops, key, total and bitmap in a small memory
// one write and one registered read per cycle; depends on frt_pkg
`default_nettype none

module frt_table #(
  parameter int SLOTS = frt_pkg::TABLE_SLOTS_DEF,
  parameter int FRAGS = frt_pkg::MAX_FRAGMENTS_DEF,
  parameter int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic                      rd_valid,
  output frt_pkg::frt_key_t         rd_key,
  output logic [frt_pkg::CNT_W-1:0] rd_cnt,
  output logic [FRAGS-1:0]          rd_bits,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic                      wr_valid,
  input  frt_pkg::frt_key_t         wr_key,
  input  logic [frt_pkg::CNT_W-1:0] wr_cnt,
  input  logic [FRAGS-1:0]          wr_bits
);
  import frt_pkg::*;

  logic [SLOTS-1:0] valid_r;
  logic             rd_valid_r;
  frt_key_t         key_mem_r  [SLOTS];
  logic [CNT_W-1:0] cnt_mem_r  [SLOTS];
  logic [FRAGS-1:0] bits_mem_r [SLOTS];
  frt_key_t         rd_key_r;
  logic [CNT_W-1:0] rd_cnt_r;
  logic [FRAGS-1:0] rd_bits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= wr_valid;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  // entry contents are only looked at while the entry is valid
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem_r[wr_addr]  <= wr_key;
      cnt_mem_r[wr_addr]  <= wr_cnt;
      bits_mem_r[wr_addr] <= wr_bits;
    end
    if (rd_en) begin
      rd_key_r  <= key_mem_r[rd_addr];
      rd_cnt_r  <= cnt_mem_r[rd_addr];
      rd_bits_r <= bits_mem_r[rd_addr];
    end
  end

  assign rd_valid = rd_valid_r;
  assign rd_key   = rd_key_r;
  assign rd_cnt   = rd_cnt_r;
  assign rd_bits  = rd_bits_r;

endmodule

`default_nettype wire

@@ hw/rtl/fragment_reassembly_tracker.sv @@
// fragment reassembly tracker: sequencer, sender ranking and table update
// depends on frt_pkg, frt_match and frt_table
//
// usage:
//   in_*  carries one received fragment header per beat (no tlast, no tuser).
//   out_* returns exactly one result beat per input beat, in order.
//   an accepted header is checked for a short frame, ranks its sender against
//   the lowest and highest addresses seen, is checked for a bad index or total,
//   then the slot table is scanned one slot per cycle through the shared key
//   compare unit and a registered memory read port, and the hit or the lowest
//   free slot is updated in the update step that follows.
// sequencing:
//   a short or bad header skips the slot scan and the update; a new header
//   is taken in the cycle after the result is loaded into the output
//   register, so headers are handled one at a time, paced by the slot scan.
// reset:
//   all slots free, no sender known; no beat is presented.
// stall:
//   the result sits in an output register; a finished result waits for
//   out_tready and the next header is accepted meanwhile, but its own result
//   waits until the register is free.
`default_nettype none

module fragment_reassembly_tracker #(
  parameter int TABLE_SLOTS   = frt_pkg::TABLE_SLOTS_DEF,
  parameter int MAX_FRAGMENTS = frt_pkg::MAX_FRAGMENTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // src_mac[47:0], msg_id[63:48], frag_index[71:64], frag_total[79:72],
  // frame_len[87:80]
  input  logic [frt_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // status[2:0], car_number[4:3], slot_used[7:5], done_id[23:8]
  output logic [frt_pkg::OUT_DATA_W-1:0] out_tdata
);
  import frt_pkg::*;

  localparam int AW   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int SCW  = $clog2(TABLE_SLOTS + 1);
  localparam logic [SCW-1:0]    SCAN_END = SCW'(TABLE_SLOTS);
  localparam logic [BYTE_W-1:0] MAX_TOT  = BYTE_W'(MAX_FRAGMENTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RANK,
    S_SCAN,
    S_UPD,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // header of the item at work
  logic [SRC_W-1:0]  src_r;
  logic [ID_W-1:0]   id_r;
  logic [BYTE_W-1:0] idx_r;
  logic [BYTE_W-1:0] tot_r;
  logic [BYTE_W-1:0] len_r;

  // sender ranking
  logic              seen_r, seen_nxt;
  logic [SRC_W-1:0]  low_r, low_nxt;
  logic [SRC_W-1:0]  high_r, high_nxt;

  // scan
  logic [SCW-1:0]    scan_r, scan_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pend_idx_r, pend_idx_nxt;
  logic              hit_found_r, hit_found_nxt;
  logic [AW-1:0]     hit_idx_r, hit_idx_nxt;
  logic [CNT_W-1:0]  hit_cnt_r, hit_cnt_nxt;
  logic [MAX_FRAGMENTS-1:0] hit_bits_r, hit_bits_nxt;
  logic              free_found_r, free_found_nxt;
  logic [AW-1:0]     free_idx_r, free_idx_nxt;

  // result
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [CAR_W-1:0]    res_car_r, res_car_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // table ports
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic                     rd_valid;
  frt_key_t                 rd_key;
  logic [CNT_W-1:0]         rd_cnt;
  logic [MAX_FRAGMENTS-1:0] rd_bits;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic                     wr_valid;
  frt_key_t                 wr_key;
  logic [CNT_W-1:0]         wr_cnt;
  logic [MAX_FRAGMENTS-1:0] wr_bits;

  frt_key_t probe_key;
  logic     cmp_hit;
  logic     cmp_free;

  // update datapath
  logic [MAX_FRAGMENTS-1:0] tot_mask;
  logic [MAX_FRAGMENTS-1:0] base_bits;
  logic [MAX_FRAGMENTS-1:0] new_bits;
  logic                     msg_done;
  logic                     accept;
  logic                     out_free;

  assign probe_key = '{src: src_r, id: id_r};
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  frt_match u_match (
    .slot_key  (rd_key),
    .probe_key (probe_key),
    .slot_valid(rd_valid),
    .hit       (cmp_hit),
    .free      (cmp_free)
  );

  frt_table #(
    .SLOTS(TABLE_SLOTS),
    .FRAGS(MAX_FRAGMENTS),
    .AW   (AW)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_valid(rd_valid),
    .rd_key  (rd_key),
    .rd_cnt  (rd_cnt),
    .rd_bits (rd_bits),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_valid(wr_valid),
    .wr_key  (wr_key),
    .wr_cnt  (wr_cnt),
    .wr_bits (wr_bits)
  );

  always_comb begin
    for (int i = 0; i < MAX_FRAGMENTS; i++) begin
      tot_mask[i] = (BYTE_W'(i) < tot_r);
    end
    if (!hit_found_r) begin
      base_bits = '0;
    end else if (hit_cnt_r != tot_r[CNT_W-1:0]) begin
      base_bits = hit_bits_r & tot_mask;
    end else begin
      base_bits = hit_bits_r;
    end
    for (int i = 0; i < MAX_FRAGMENTS; i++) begin
      new_bits[i] = base_bits[i] || (idx_r == BYTE_W'(i));
    end
    msg_done = (new_bits == tot_mask);
  end

  always_comb begin
    state_nxt      = state_r;
    seen_nxt       = seen_r;
    low_nxt        = low_r;
    high_nxt       = high_r;
    scan_nxt       = scan_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_cnt_nxt    = hit_cnt_r;
    hit_bits_nxt   = hit_bits_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    res_status_nxt = res_status_r;
    res_car_nxt    = res_car_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    rd_en          = 1'b0;
    rd_addr        = scan_r[AW-1:0];
    wr_en          = 1'b0;
    wr_addr        = hit_found_r ? hit_idx_r : free_idx_r;
    wr_valid       = !msg_done;
    wr_key         = probe_key;
    wr_cnt         = tot_r[CNT_W-1:0];
    wr_bits        = new_bits;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RANK;
        end
      end
      S_RANK: begin
        res_slot_nxt = '0;
        if (len_r < MIN_FRAME_LEN) begin
          res_status_nxt = ST_SHORT;
          res_car_nxt    = CAR_NONE;
          state_nxt      = S_DONE;
        end else begin
          if (!seen_r) begin
            low_nxt  = src_r;
            high_nxt = src_r;
          end else begin
            if (src_r < low_r) low_nxt = src_r;
            if (src_r > high_r) high_nxt = src_r;
          end
          seen_nxt = 1'b1;
          if (src_r == low_nxt) begin
            res_car_nxt = CAR_LOWEST;
          end else if (low_nxt != high_nxt && src_r == high_nxt) begin
            res_car_nxt = CAR_HIGHEST;
          end else begin
            res_car_nxt = CAR_NONE;
          end
          if (tot_r == '0 || tot_r > MAX_TOT || idx_r >= tot_r) begin
            res_status_nxt = ST_BAD;
            state_nxt      = S_DONE;
          end else begin
            scan_nxt       = '0;
            hit_found_nxt  = 1'b0;
            free_found_nxt = 1'b0;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // read one slot per cycle, compare the slot read the cycle before
        if (scan_r != SCAN_END) begin
          rd_en        = 1'b1;
          scan_nxt     = scan_r + 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_r[AW-1:0];
        end else begin
          state_nxt = S_UPD;
        end
        if (pend_r) begin
          if (cmp_hit && !hit_found_r) begin
            hit_found_nxt = 1'b1;
            hit_idx_nxt   = pend_idx_r;
            hit_cnt_nxt   = rd_cnt;
            hit_bits_nxt  = rd_bits;
          end
          if (cmp_free && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = pend_idx_r;
          end
        end
      end
      S_UPD: begin
        if (!hit_found_r && !free_found_r) begin
          res_status_nxt = ST_FULL;
          res_slot_nxt   = '0;
        end else begin
          wr_en          = 1'b1;
          res_status_nxt = msg_done ? ST_COMPLETE : ST_STORED;
          res_slot_nxt   = SLOT_W'(wr_addr);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {id_r, res_slot_r, res_car_r, res_status_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      seen_r       <= 1'b0;
      low_r        <= '0;
      high_r       <= '0;
      scan_r       <= '0;
      pend_r       <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      seen_r       <= seen_nxt;
      low_r        <= low_nxt;
      high_r       <= high_nxt;
      scan_r       <= scan_nxt;
      pend_r       <= pend_nxt;
      hit_found_r  <= hit_found_nxt;
      free_found_r <= free_found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      src_r <= in_tdata[SRC_W-1:0];
      id_r  <= in_tdata[SRC_W +: ID_W];
      idx_r <= in_tdata[SRC_W + ID_W +: BYTE_W];
      tot_r <= in_tdata[SRC_W + ID_W + BYTE_W +: BYTE_W];
      len_r <= in_tdata[SRC_W + ID_W + 2 * BYTE_W +: BYTE_W];
    end
    pend_idx_r   <= pend_idx_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_cnt_r    <= hit_cnt_nxt;
    hit_bits_r   <= hit_bits_nxt;
    free_idx_r   <= free_idx_nxt;
    res_status_r <= res_status_nxt;
    res_car_r    <= res_car_nxt;
    res_slot_r   <= res_slot_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // one header at a time: the sequencer leaves idle right after a beat
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("header accepted while another is at work");

  // the update step only follows a scan that visited every slot
  a_scan_complete: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD |-> scan_r == SCAN_END && !pend_r)
    else $error("table update before the scan finished");

  // a short frame neither ranks its sender nor names a slot
  a_short_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[STATUS_W-1:0] == ST_SHORT
      |-> out_data_r[STATUS_W +: CAR_W + SLOT_W] == '0)
    else $error("short frame result carries rank or slot");

  // the full status is only given when no slot was hit and none was free
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD && (hit_found_r || free_found_r) |=> res_status_r != ST_FULL)
    else $error("table full reported with a usable slot");

endmodule

`default_nettype wire
